### sv/cpba_pkg.sv
package cpba_pkg;

  // default sizing
  localparam int unsigned PageCountDef = 4096;
  localparam int unsigned RunMaxDef    = 64;
  localparam int unsigned FlagBitsDef  = 10;
  localparam int unsigned RefBitDef    = 2;
  localparam int unsigned ShareBitDef  = 8;

  // fixed field widths
  localparam int unsigned PageW  = 12;
  localparam int unsigned LenW   = 7;
  localparam int unsigned FlagW  = 10;
  localparam int unsigned CountW = 13;
  localparam int unsigned RegCount = 6;
  localparam int unsigned RegIdxW  = 3;

  typedef enum logic [1:0] {
    FuncAlloc   = 2'd0,
    FuncMark    = 2'd1,
    FuncRelease = 2'd2,
    FuncNop     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatBadZone = 2'd1,
    StatNoRun   = 2'd2,
    StatBadLen  = 2'd3
  } status_e;

  localparam logic [1:0] ZoneInvalid = 2'd3;

endpackage

### sv/contiguous_page_bitmap_allocator.sv
// channel | dir | signals                          | contents
// s_axis  | in  | tvalid tready tdata[31:0] tuser  | one request item
// m_axis  | out | tvalid tready tdata[31:0]        | one result item per request
// cfg     | in  | cfg_valid_i cfg_ready_o idx data | zone range register write
//
// steps: mark and release visit one page; allocate scans the pages of the zone,
// then updates each page of the run (each page scanned is read; each page updated is
// read, then written back, on the single page table memory)
// reset: a clearing pass writes every page entry to zero, during which no item
// is accepted; config writes are taken at any time
// stalls: a held result blocks only the end of the next item
module contiguous_page_bitmap_allocator #(
  parameter int unsigned PAGE_COUNT = cpba_pkg::PageCountDef,
  parameter int unsigned RUN_MAX    = cpba_pkg::RunMaxDef,
  parameter int unsigned FLAG_BITS  = cpba_pkg::FlagBitsDef,
  parameter int unsigned REF_BIT    = cpba_pkg::RefBitDef,
  parameter int unsigned SHARE_BIT  = cpba_pkg::ShareBitDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // run_length[6:0], attr_flags[16:7], page_index[28:17], zeros above
  input  logic [31:0] s_axis_tdata,
  // func[1:0], zone_sel[3:2]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], first_page[13:2], free_count[26:14], zeros above
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [cpba_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [cpba_pkg::PageW-1:0]   cfg_data_i
);

  localparam int unsigned AW  = $clog2(PAGE_COUNT);
  localparam int unsigned PW  = ((AW > cpba_pkg::PageW) ? AW : cpba_pkg::PageW) + 1;
  localparam int unsigned FW  = $clog2(PAGE_COUNT + 1);
  localparam int unsigned RLW = $clog2(RUN_MAX + 1);
  localparam int unsigned RW  = 16;
  localparam int unsigned EW  = 1 + FLAG_BITS + RW;
  localparam logic [PW-1:0] LastPage = PW'(PAGE_COUNT - 1);
  localparam logic [FLAG_BITS-1:0] LinkMask =
    FLAG_BITS'((64'(1) << REF_BIT) | (64'(1) << SHARE_BIT));

  typedef enum logic [2:0] {
    StClear, StIdle, StScanRd, StScanEv, StPgRd, StPgEv, StDone
  } state_e;

  // request fields
  logic [1:0]               func_in, zone_in;
  logic [cpba_pkg::LenW-1:0] len_in;
  logic [cpba_pkg::FlagW-1:0] flags_in;
  logic [cpba_pkg::PageW-1:0] page_in;
  assign func_in  = s_axis_tuser[1:0];
  assign zone_in  = s_axis_tuser[3:2];
  assign len_in   = s_axis_tdata[6:0];
  assign flags_in = s_axis_tdata[16:7];
  assign page_in  = s_axis_tdata[28:17];

  state_e state_q;
  logic [cpba_pkg::PageW-1:0] cfg_q [cpba_pkg::RegCount];
  logic [PW-1:0]        p_q, hi_q;
  logic [RLW-1:0]       run_q, len_q, cnt_q;
  logic [FLAG_BITS-1:0] flags_q;
  logic                 rel_q;
  logic [FW-1:0]        free_q;
  logic [1:0]           stat_q;
  logic [cpba_pkg::PageW-1:0] first_q;
  logic                 out_valid_q;
  logic [31:0]          out_data_q;

  // page table memory: {used, attr, refs}
  logic [EW-1:0] mem [PAGE_COUNT];
  logic [EW-1:0] rdata_q, wdata;
  logic          we;
  logic [AW-1:0] addr;
  assign addr = p_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_q <= mem[addr];
  end

  // read-modify-write of one entry
  logic                 e_used, n_used;
  logic [FLAG_BITS-1:0] e_attr, n_attr;
  logic [RW-1:0]        e_refs, n_refs, refs_up, refs_dn;
  assign {e_used, e_attr, e_refs} = rdata_q;
  assign refs_up = (e_refs == '1) ? e_refs : e_refs + RW'(1);
  assign refs_dn = (e_refs == '0) ? e_refs : e_refs - RW'(1);

  always_comb begin
    n_used = e_used;
    n_attr = e_attr;
    n_refs = e_refs;
    if (!rel_q) begin
      if (e_attr == '0) begin
        n_used = 1'b1;
        n_attr = flags_q;
        n_refs = refs_up;
      end else if (|((e_attr | flags_q) & LinkMask)) begin
        n_attr = e_attr | flags_q;
        n_refs = refs_up;
      end else begin
        n_used = 1'b1;
        n_attr = e_attr | flags_q;
      end
    end else if (e_attr != '0) begin
      if (|(e_attr & LinkMask)) begin
        n_refs = refs_dn;
        if (refs_dn == '0) begin
          n_attr = '0;
          n_used = 1'b0;
        end
      end else begin
        n_used = 1'b0;
        n_attr = '0;
        n_refs = '0;
      end
    end
  end

  assign we    = (state_q == StClear) || (state_q == StPgEv);
  assign wdata = (state_q == StClear) ? '0 : {n_used, n_attr, n_refs};

  // zone range lookup, last page clamped to memory
  logic [PW-1:0] lo_sel, hi_raw, hi_sel;
  always_comb begin
    lo_sel = PW'(cfg_q[{zone_in, 1'b0}]);
    hi_raw = PW'(cfg_q[{zone_in, 1'b1}]);
    hi_sel = (hi_raw > LastPage) ? LastPage : hi_raw;
  end

  logic [RLW-1:0] run_n;
  assign run_n = e_used ? '0 : run_q + RLW'(1);

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      p_q         <= '0;
      free_q      <= FW'(PAGE_COUNT);
      out_valid_q <= 1'b0;
      for (int i = 0; i < cpba_pkg::RegCount; i++) begin
        cfg_q[i] <= (i % 2 == 1) ? '1 : '0;
      end
    end else begin
      if (cfg_valid_i && cfg_index_i < cpba_pkg::RegIdxW'(cpba_pkg::RegCount)) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
      // result taken; in StDone the valid flag is handled below
      if (out_valid_q && m_axis_tready && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          p_q <= p_q + PW'(1);
          if (p_q == LastPage) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (s_axis_tvalid) begin
            flags_q <= FLAG_BITS'(flags_in);
            first_q <= '0;
            stat_q  <= cpba_pkg::StatOk;
            cnt_q   <= RLW'(1);
            state_q <= StDone;
            case (func_in)
              cpba_pkg::FuncAlloc: begin
                rel_q <= 1'b0;
                if (zone_in == cpba_pkg::ZoneInvalid) begin
                  stat_q <= cpba_pkg::StatBadZone;
                end else if (len_in == '0 || len_in > cpba_pkg::LenW'(RUN_MAX)) begin
                  stat_q <= cpba_pkg::StatBadLen;
                end else if (lo_sel > hi_sel) begin
                  stat_q <= cpba_pkg::StatNoRun;
                end else begin
                  len_q   <= RLW'(len_in);
                  run_q   <= '0;
                  p_q     <= lo_sel;
                  hi_q    <= hi_sel;
                  state_q <= StScanRd;
                end
              end
              cpba_pkg::FuncMark, cpba_pkg::FuncRelease: begin
                rel_q   <= (func_in == cpba_pkg::FuncRelease);
                first_q <= page_in;
                if (PW'(page_in) <= LastPage) begin
                  p_q     <= PW'(page_in);
                  state_q <= StPgRd;
                end
              end
              default: ;
            endcase
          end
        end
        StScanRd: state_q <= StScanEv;
        StScanEv: begin
          run_q <= run_n;
          if (run_n == len_q) begin
            p_q     <= p_q + PW'(1) - PW'(len_q);
            first_q <= cpba_pkg::PageW'(p_q + PW'(1) - PW'(len_q));
            cnt_q   <= len_q;
            state_q <= StPgRd;
          end else if (p_q == hi_q) begin
            stat_q  <= cpba_pkg::StatNoRun;
            state_q <= StDone;
          end else begin
            p_q     <= p_q + PW'(1);
            state_q <= StScanRd;
          end
        end
        StPgRd: state_q <= StPgEv;
        StPgEv: begin
          if (!e_used && n_used && free_q != '0) begin
            free_q <= free_q - FW'(1);
          end else if (e_used && !n_used && free_q != FW'(PAGE_COUNT)) begin
            free_q <= free_q + FW'(1);
          end
          p_q   <= p_q + PW'(1);
          cnt_q <= cnt_q - RLW'(1);
          state_q <= (cnt_q == RLW'(1)) ? StDone : StPgRd;
        end
        StDone: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {5'd0, cpba_pkg::CountW'(free_q), first_q, stat_q};
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // free count never exceeds memory size
  assert property (@(posedge clk_i) disable iff (!rst_ni) free_q <= FW'(PAGE_COUNT))
    else $error("free count overflow");

  // page updates always have pages left to visit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPgEv) |-> (cnt_q != '0))
    else $error("page loop count underflow");

  // a found run leads to the page updates and the result is ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScanEv && run_n == len_q) |=> (state_q == StPgRd && stat_q == cpba_pkg::StatOk))
    else $error("run found but status not ok");

endmodule
